FILE: hw/rtl/itp_pkg.sv
// Package for the infix to postfix converter: payload types, operator codes and lookup functions.
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  // ASCII characters of the parentheses and the operators.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  // Operator codes as they are kept on the stack.
  typedef logic [2:0] op_code_t;

  localparam op_code_t OP_OPEN = 3'd0;
  localparam op_code_t OP_ADD  = 3'd1;
  localparam op_code_t OP_SUB  = 3'd2;
  localparam op_code_t OP_MUL  = 3'd3;
  localparam op_code_t OP_DIV  = 3'd4;
  localparam op_code_t OP_POW  = 3'd5;

  typedef struct packed {
    logic [7:0] in_char;
    logic       expr_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       expr_end;
    logic       stack_overflow;
    logic       unmatched_close;
  } out_t;

  // ASCII character for a stack code.
  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] c;
    unique case (code)
      OP_OPEN: c = CH_OPEN;
      OP_ADD:  c = CH_PLUS;
      OP_SUB:  c = CH_MINUS;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_POW:  c = CH_POW;
      default: c = CH_OPEN;
    endcase
    return c;
  endfunction

  // Binding strength; an opening parenthesis has the lowest.
  function automatic logic [1:0] op_prec(input op_code_t code);
    logic [1:0] p;
    unique case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) || (c == CH_DIV) ||
           (c == CH_POW);
  endfunction

  // Stack code of an operator character; only meaningful where is_operator holds.
  function automatic op_code_t char_to_op(input logic [7:0] c);
    op_code_t code;
    unique case (c)
      CH_PLUS:  code = OP_ADD;
      CH_MINUS: code = OP_SUB;
      CH_MUL:   code = OP_MUL;
      CH_DIV:   code = OP_DIV;
      CH_POW:   code = OP_POW;
      default:  code = OP_OPEN;
    endcase
    return code;
  endfunction

endpackage

FILE: hw/rtl/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix to postfix converter with its operator stack.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         in_valid_i / in_ready_o    in_data_i  (in_t: in_char, expr_last)
//   output   out        out_valid_o / out_ready_i  out_data_o (out_t: postfix char and flags)
//
// One request is taken while the sequencer is idle, after which the input stays not ready
// until every result of that request has been placed in the output register.
// Each popped operator passes through S_POP and then S_LOAD, where the stack memory's
// registered read supplies the new top; S_LOAD is skipped when the pop empties the stack.
// Discarding an opening parenthesis with entries below it passes through S_LOAD too, and a
// final character adds a flush phase that pops every operator left on the stack.
// Reset clears the stack count and the sequencer; the stack memory is not cleared,
// because only entries below the count are ever read. A stalled output holds the
// sequencer in place, so no result is lost or repeated.
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Phase of the pop loop: the character's own popping, the final flush, or done.
  localparam logic [1:0] M_MAIN  = 2'd0;
  localparam logic [1:0] M_DONE  = 2'd1;
  localparam logic [1:0] M_FLUSH = 2'd2;

  // Classes of input character.
  localparam logic K_CLOSE = 1'b0;
  localparam logic K_OPER  = 1'b1;

  logic [1:0]    state_q, state_d;
  logic [1:0]    mode_q, mode_d;
  logic          kind_q, kind_d;
  op_code_t      code_q, code_d;
  logic          last_q, last_d;
  logic          ovf_q, ovf_d;
  logic          unm_q, unm_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] open_q, open_d;
  op_code_t      top_q, top_d;
  logic          pend_v_q, pend_v_d;
  logic [7:0]    pend_char_q, pend_char_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  // Stack memory holds every entry below the cached top.
  op_code_t      stack_mem [STACK_DEPTH];
  op_code_t      rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  logic          out_free;
  logic          pop_cond;
  logic          full;
  op_code_t      in_code;
  logic [7:0]    in_char;

  assign in_char  = in_data_i.in_char;
  assign in_code  = char_to_op(in_char);
  assign cnt_m1   = count_q - CW'(1);
  assign cnt_m2   = count_q - CW'(2);
  assign mem_wa   = cnt_m1[AW-1:0];
  assign mem_ra   = cnt_m2[AW-1:0];
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= top_q;
    end
    rd_data_q <= stack_mem[mem_ra];
  end

  always_comb begin
    unique case (mode_q)
      M_MAIN: begin
        if (kind_q == K_CLOSE) begin
          pop_cond = (count_q != '0) && (top_q != OP_OPEN);
        end else begin
          pop_cond = (count_q != '0) && (op_prec(top_q) >= op_prec(code_q));
        end
      end
      M_FLUSH: pop_cond = (count_q != '0);
      default: pop_cond = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    kind_d      = kind_q;
    code_d      = code_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    unm_d       = unm_q;
    count_d     = count_q;
    open_d      = open_q;
    top_d       = top_q;
    pend_v_d    = pend_v_q;
    pend_char_d = pend_char_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    in_ready_o  = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d   = in_data_i.expr_last;
          code_d   = in_code;
          ovf_d    = 1'b0;
          unm_d    = 1'b0;
          pend_v_d = 1'b0;
          mode_d   = M_DONE;
          state_d  = S_POP;
          if (is_alnum(in_char)) begin
            pend_v_d    = 1'b1;
            pend_char_d = in_char;
          end else if (in_char == CH_OPEN) begin
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              mem_we  = (count_q != '0);
              top_d   = OP_OPEN;
              count_d = count_q + CW'(1);
              open_d  = open_q + CW'(1);
            end
          end else if (in_char == CH_CLOSE) begin
            kind_d = K_CLOSE;
            mode_d = M_MAIN;
            unm_d  = (open_q == '0);
          end else if (is_operator(in_char)) begin
            kind_d = K_OPER;
            mode_d = M_MAIN;
            // A full stack only overflows when nothing is popped first.
            ovf_d  = full && (op_prec(top_q) < op_prec(in_code));
          end
        end
      end

      S_POP: begin
        if (pop_cond) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_d       = '{out_char: pend_char_q, char_valid: 1'b1, run_last: 1'b0,
                              expr_end: 1'b0, stack_overflow: ovf_q,
                              unmatched_close: unm_q};
            end
            pend_v_d    = 1'b1;
            pend_char_d = op_char(top_q);
            count_d     = cnt_m1;
            if (count_q > CW'(1)) begin
              state_d = S_LOAD;
            end
          end
        end else begin
          unique case (mode_q)
            M_MAIN: begin
              mode_d = M_DONE;
              if (kind_q == K_CLOSE) begin
                // Discard the matching opening parenthesis.
                if (count_q != '0) begin
                  count_d = cnt_m1;
                  open_d  = open_q - CW'(1);
                  if (count_q > CW'(1)) begin
                    state_d = S_LOAD;
                  end
                end
              end else if (!full) begin
                mem_we  = (count_q != '0);
                top_d   = code_q;
                count_d = count_q + CW'(1);
              end
            end
            M_DONE: begin
              if (last_q) begin
                mode_d = M_FLUSH;
              end else begin
                state_d = S_FIN;
              end
            end
            default: begin
              open_d  = '0;
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_LOAD: begin
        top_d   = rd_data_q;
        state_d = S_POP;
      end

      default: begin
        if (pend_v_q || last_q || ovf_q || unm_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{out_char: pend_v_q ? pend_char_q : 8'h00, char_valid: pend_v_q,
                            run_last: 1'b1, expr_end: last_q, stack_overflow: ovf_q,
                            unmatched_close: unm_q};
            pend_v_d    = 1'b0;
            state_d     = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_DONE;
      count_q     <= '0;
      open_q      <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      open_q      <= open_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    code_q      <= code_d;
    last_q      <= last_d;
    ovf_q       <= ovf_d;
    unm_q       <= unm_d;
    top_q       <= top_d;
    pend_char_q <= pend_char_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
